>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Holds the cell layout, the operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int FUNC_W  = 2;

  localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0]  NULL_CHAR    = 8'h00;
  localparam logic [COLOR_W-1:0] RESET_FG     = 4'hF;
  localparam logic [COLOR_W-1:0] RESET_BG     = 4'h0;
  localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_BG, RESET_FG, BLANK_CHAR};

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR = 1'b0,
    CFG_BG_COLOR = 1'b1
  } cfg_reg_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_BLANK,
    ST_WRITE,
    ST_READ,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

>>> rtl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: character-cell console with cursor, scroll and readback
//
// Usage:
//   s_axis carries one command per transaction: tuser is the operation (put,
//   clear, read), tdata the character and the row/column of a read. m_axis
//   returns one result per command: the cell read (zero for other commands)
//   and the cursor after it. cfg_* writes the foreground (index 0) and
//   background (index 1) color nibbles; it is always ready. Write
//   configuration only while no command is in flight.
// Timing: one command at a time; s_axis_tready is low from acceptance until
//   the result transaction completes. The sequencer works over one RAM port
//   pair: a put without scroll writes the cell, a read in range reads it;
//   a newline without scroll, a zero character, a read out of range and an
//   unused code go straight to the result; clear blanks every cell; a put
//   that scrolls moves each row up one (each cell by a RAM read, then a
//   write back), blanks the last row and writes the character, a newline
//   that scrolls the same without the write.
// Reset: the cursor homes and the colors return to white on black; then a
//   clearing pass fills the screen with white spaces on black and no command
//   is taken until it ends.
// Stall: a result waits in its output register while m_axis_tready is low;
//   the block holds its state and takes no new command meanwhile.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int ROW_W  = $clog2(ROWS),
  localparam int COL_W  = $clog2(COLUMNS + 1),
  localparam int IN_W   = ((tcw_pkg::CHAR_W + ROW_W + COL_W + 7) / 8) * 8,
  localparam int OUT_W  = ((tcw_pkg::CELL_W + ROW_W + COL_W + 7) / 8) * 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Command stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: char_code, read_row, read_col (low to high), zero padded
  input  wire  [IN_W-1:0]                   s_axis_tdata,
  // tuser: func
  input  wire  [tcw_pkg::FUNC_W-1:0]        s_axis_tuser,
  // Result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata: cell_data, cursor_row, cursor_col (low to high), zero padded
  output logic [OUT_W-1:0]                  m_axis_tdata,
  // Configuration writes
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [tcw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [tcw_pkg::COLOR_W-1:0]       cfg_data_i
);

  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PAD_IN = IN_W - CHAR_W - ROW_W - COL_W;
  localparam int PAD_OUT = OUT_W - CELL_W - ROW_W - COL_W;

  localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] FIRST_LAST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  WRAP_COL   = COL_W'(COLUMNS);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   idx_q, idx_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [COLOR_W-1:0]  fg_q, bg_q;
  logic [CELL_W-1:0]   data_q, data_d;

  // Latched command payload
  func_e               func_q;
  logic [CHAR_W-1:0]   char_q;
  logic [ROW_W-1:0]    rrow_q;
  logic [COL_W-1:0]    rcol_q;

  // RAM port
  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [CELL_W-1:0]   wdata, rdata;

  // Address unit inputs and derived conditions
  logic [ADDR_W-1:0]   cursor_addr, read_addr;
  logic [CELL_W-1:0]   blank_cell, char_cell;
  logic                read_in_range, wrap, is_newline;

  assign cursor_addr   = ADDR_W'(row_q) * ROW_STRIDE + ADDR_W'(col_q);
  assign read_addr     = ADDR_W'(rrow_q) * ROW_STRIDE + ADDR_W'(rcol_q);
  assign read_in_range = (32'(rrow_q) < 32'(ROWS)) && (32'(rcol_q) < 32'(COLUMNS));
  assign blank_cell    = {bg_q, fg_q, BLANK_CHAR};
  assign char_cell     = {bg_q, fg_q, char_q};
  assign is_newline    = (char_q == NEWLINE_CHAR);
  assign wrap          = (col_q == WRAP_COL) || is_newline;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (idx_q == LAST_CELL) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (func_q)
          FUNC_PUT: begin
            if (char_q == NULL_CHAR) begin
              state_d = ST_RESP;
            end else if (wrap && (row_q == LAST_ROW)) begin
              state_d = ST_SCROLL_RD;
            end else if (is_newline) begin
              state_d = ST_RESP;
            end else begin
              state_d = ST_WRITE;
            end
          end
          FUNC_CLEAR: state_d = ST_BLANK;
          FUNC_READ:  state_d = read_in_range ? ST_READ : ST_RESP;
          default:    state_d = ST_RESP;
        endcase
      end
      ST_SCROLL_RD: state_d = ST_SCROLL_WR;
      ST_SCROLL_WR: begin
        state_d = (idx_q == LAST_COPY) ? ST_BLANK : ST_SCROLL_RD;
      end
      ST_BLANK: begin
        if (idx_q == LAST_CELL) begin
          if (func_q == FUNC_CLEAR || is_newline) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: state_d = ST_RESP;
      ST_READ:  state_d = ST_RESP;
      ST_RESP: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    idx_d  = idx_q;
    row_d  = row_q;
    col_d  = col_q;
    data_d = data_q;
    we     = 1'b0;
    waddr  = idx_q;
    wdata  = blank_cell;
    raddr  = read_addr;
    unique case (state_q)
      ST_INIT: begin
        // Reset pass: fixed white-on-black spaces whatever the colors are
        we    = 1'b1;
        wdata = RESET_CELL;
        idx_d = idx_q + 1'b1;
      end
      ST_IDLE: begin
        idx_d = '0;
      end
      ST_EXEC: begin
        data_d = '0;
        case (func_q)
          FUNC_PUT: begin
            if (char_q != NULL_CHAR && wrap) begin
              col_d = '0;
              if (row_q != LAST_ROW) row_d = row_q + 1'b1;
            end
          end
          FUNC_CLEAR: begin
            row_d = '0;
            col_d = '0;
          end
          default: ;
        endcase
      end
      ST_SCROLL_RD: begin
        raddr = idx_q + ROW_STRIDE;
      end
      ST_SCROLL_WR: begin
        we    = 1'b1;
        wdata = rdata;
        idx_d = (idx_q == LAST_COPY) ? FIRST_LAST : idx_q + 1'b1;
      end
      ST_BLANK: begin
        we    = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      ST_WRITE: begin
        we    = 1'b1;
        waddr = cursor_addr;
        wdata = char_cell;
        col_d = col_q + 1'b1;
      end
      ST_READ: begin
        data_d = rdata;
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      fg_q    <= RESET_FG;
      bg_q    <= RESET_BG;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_FG_COLOR: fg_q <= cfg_data_i;
          CFG_BG_COLOR: bg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Hold the command and the result payload; no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= func_e'(s_axis_tuser);
      char_q <= s_axis_tdata[CHAR_W-1:0];
      rrow_q <= s_axis_tdata[CHAR_W +: ROW_W];
      rcol_q <= s_axis_tdata[CHAR_W + ROW_W +: COL_W];
    end
  end

  // --------------------------------------------------------------------------
  // Screen memory
  // --------------------------------------------------------------------------
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_RESP);
  assign cfg_ready_o   = 1'b1;

  if (PAD_OUT > 0) begin : g_pad_out
    assign m_axis_tdata = {{PAD_OUT{1'b0}}, col_q, row_q, data_q};
  end else begin : g_nopad_out
    assign m_axis_tdata = {col_q, row_q, data_q};
  end

  // Padding bits of the command stream carry nothing
  if (PAD_IN > 0) begin : g_pad_in
    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[IN_W-1 -: PAD_IN];
  end

endmodule
`default_nettype wire
